// File: rtl/core/ledpg_pkg.sv
// Shared types and constants for the LED effect pattern generator.
// No dependencies; every other file of the block imports this package.
package ledpg_pkg;

   localparam int PIXEL_INDEX_W = 6;
   localparam int CHANNEL_W     = 8;
   localparam int COLOR_W       = 24;
   localparam int PHASE_W       = 7;
   localparam int MODE_W        = 3;
   localparam int CSR_INDEX_W   = 2;
   localparam int QUEUE_DEPTH   = 2;

   // effect_mode register codes
   localparam logic [MODE_W-1:0] MODE_CHASE        = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DOUBLE_CHASE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_BREATHE      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FLASH        = 3'd4;
   localparam logic [MODE_W-1:0] MODE_HUE_CHASE    = 3'd5;
   localparam logic [MODE_W-1:0] MODE_HUE_SWEEP    = 3'd6;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_EFFECT_MODE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_COLOR  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_COLOR = 2'd2;

   // register reset values
   localparam logic [MODE_W-1:0]  MODE_RESET         = MODE_CHASE;
   localparam logic [COLOR_W-1:0] FIRST_COLOR_RESET  = 24'hff0000;
   localparam logic [COLOR_W-1:0] SECOND_COLOR_RESET = 24'hffffff;

   // effect class decided at the front, carried out at the back
   typedef enum logic [2:0] {
      EFFECT_BLACK,
      EFFECT_CHASE,
      EFFECT_DOUBLE_CHASE,
      EFFECT_PULSE,
      EFFECT_BLINK,
      EFFECT_THEATRE,
      EFFECT_RAINBOW
   } effect_type;

   // one queued frame job
   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      effect_type         effect;
   } frame_type;

   typedef struct packed {
      logic [COLOR_W-1:0] first_color;
      logic [COLOR_W-1:0] second_color;
   } palette_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: rtl/core/ledpg_channels.sv
// Valid/ready channel interfaces for frame requests and pixel responses.
// Depends on ledpg_pkg for field widths.
interface ledpg_req_if import ledpg_pkg::*; ();
   logic valid;
   logic ready;
   logic advance;

   modport source (output valid, output advance, input ready);
   modport sink   (input valid, input advance, output ready);
endinterface

interface ledpg_rsp_if import ledpg_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [PIXEL_INDEX_W-1:0] pixel_index;
   logic [CHANNEL_W-1:0]     red;
   logic [CHANNEL_W-1:0]     green;
   logic [CHANNEL_W-1:0]     blue;
   logic                     last_pixel;

   modport source (output valid, output pixel_index, output red, output green,
                   output blue, output last_pixel, input ready);
   modport sink   (input valid, input pixel_index, input red, input green,
                   input blue, input last_pixel, output ready);
endinterface

// File: rtl/core/led_effect_pattern_generator.sv
// Top level of the LED effect pattern generator: front end, job queue and
// pixel engine. Depends on ledpg_pkg, ledpg_channels, ledpg_front/queue/back.
//
//   port group   direction  transaction
//   req_ch       in         one frame tick with the advance bit
//   rsp_ch       out        one pixel: index, red, green, blue, last flag
//   csr_*        in         register write, index 0 mode, 1 and 2 colors
//
// The pixel counter issues one pixel a cycle while rsp_ch is not stalled, and
// the next job is loaded from the queue after the last pixel is issued.
// A job's first pixel reaches rsp_ch through stage registers 1 to 3 and out_ff.
// Up to two ticks wait in the queue; req_ch.ready drops only when it is full.
// A low rsp_ch.ready freezes the whole pixel pipeline; nothing is dropped.
// Synchronous active-high reset; no clearing pass.
module led_effect_pattern_generator import ledpg_pkg::*; #(
   parameter int PIXELS = 40
) (
   input  logic                   clock,
   input  logic                   reset,
   ledpg_req_if.sink              req_ch,
   ledpg_rsp_if.source            rsp_ch,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]     csr_write_data
);

   queue_status_type q_status;
   logic             push;
   logic             pop;
   frame_type        push_frame;
   frame_type        pop_frame;
   palette_type      palette;

   ledpg_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_status         (q_status),
      .push             (push),
      .push_frame       (push_frame),
      .palette          (palette)
   );

   ledpg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .pop        (pop),
      .pop_frame  (pop_frame),
      .status     (q_status)
   );

   ledpg_back #(
      .PIXELS (PIXELS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .q_frame  (pop_frame),
      .pop      (pop),
      .palette  (palette),
      .rsp_ch   (rsp_ch)
   );

endmodule

// File: rtl/core/ledpg_front.sv
// Front end: configuration registers, request acceptance, phase tracking.
// Classifies each request into a frame job for the queue. Uses ledpg_pkg.
module ledpg_front import ledpg_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   ledpg_req_if.sink              req_ch,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]     csr_write_data,
   input  queue_status_type       q_status,
   output logic                   push,
   output frame_type              push_frame,
   output palette_type            palette
);

   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [COLOR_W-1:0] first_ff, first_in;
   logic [COLOR_W-1:0] second_ff, second_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   effect_type         effect;

   // register writes
   always_comb begin
      mode_in   = mode_ff;
      first_in  = first_ff;
      second_in = second_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_EFFECT_MODE:  mode_in   = csr_write_data[MODE_W-1:0];
            CSR_FIRST_COLOR:  first_in  = csr_write_data;
            CSR_SECOND_COLOR: second_in = csr_write_data;
            default: ;
         endcase
      end
   end

   // mode to effect class; codes without meaning render black
   always_comb begin
      unique case (mode_ff)
         MODE_CHASE:        effect = EFFECT_CHASE;
         MODE_DOUBLE_CHASE: effect = EFFECT_DOUBLE_CHASE;
         MODE_BREATHE:      effect = EFFECT_PULSE;
         MODE_FLASH:        effect = EFFECT_BLINK;
         MODE_HUE_CHASE:    effect = EFFECT_THEATRE;
         MODE_HUE_SWEEP:    effect = EFFECT_RAINBOW;
         default:           effect = EFFECT_BLACK;
      endcase
   end

   // accept while the queue has room; the frame keeps the phase it starts with
   assign req_ch.ready      = !q_status.full;
   assign push              = req_ch.valid && !q_status.full;
   assign push_frame.phase  = phase_ff;
   assign push_frame.effect = effect;
   assign phase_in          = (push && req_ch.advance) ? phase_ff + 1'b1 : phase_ff;

   assign palette.first_color  = first_ff;
   assign palette.second_color = second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RESET;
         first_ff  <= FIRST_COLOR_RESET;
         second_ff <= SECOND_COLOR_RESET;
         phase_ff  <= '0;
      end else begin
         mode_ff   <= mode_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         phase_ff  <= phase_in;
      end
   end

endmodule

// File: rtl/core/ledpg_queue.sv
// Short frame job queue between the front end and the pixel engine.
// Depth from ledpg_pkg::QUEUE_DEPTH; uses ledpg_pkg types.
module ledpg_queue import ledpg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  frame_type        push_frame,
   input  logic             pop,
   output frame_type        pop_frame,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   frame_type        entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
   assign rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_frame    = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/core/ledpg_back.sv
// Pixel engine: walks the pixels of one frame job and renders each through
// a four-stage pipeline into the response register. Uses ledpg_pkg.
module ledpg_back import ledpg_pkg::*; #(
   parameter int PIXELS = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  frame_type        q_frame,
   output logic             pop,
   input  palette_type      palette,
   ledpg_rsp_if.source      rsp_ch
);

   localparam int CHANNELS    = 3;
   localparam int BASE        = 896 / PIXELS;
   localparam int OFFS_STEP   = 128 / PIXELS;
   localparam int REM_STEP    = 128 % PIXELS;
   localparam int REM_W       = $clog2(2 * PIXELS);
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP       = (1 << RECIP_SHIFT) / BASE;
   localparam int PROD_W      = 15;
   localparam int WIDE_W      = 28;
   localparam int HUE_W       = 16;
   localparam int H_W         = 11;
   localparam int HUE_SCALE   = 1530;
   localparam int HUE_ROUND   = 32768;

   localparam logic [PIXEL_INDEX_W-1:0] LAST_IDX = PIXEL_INDEX_W'(PIXELS - 1);
   localparam logic [PHASE_W-1:0] BASE_X  = PHASE_W'(BASE);
   localparam logic [PHASE_W-1:0] HALF    = 7'd64;
   localparam logic [PHASE_W-1:0] QUARTER = 7'd32;
   localparam logic [PHASE_W-1:0] THREE_Q = 7'd96;

   typedef enum logic [1:0] {SPAN_BASE, SPAN_64, SPAN_32} span_type;

   typedef struct packed {
      logic [PIXEL_INDEX_W-1:0] idx;
      logic                     last;
      effect_type               effect;
      span_type                 span;
      logic [PHASE_W-1:0]       x;
      logic [COLOR_W-1:0]       c0;
      logic [COLOR_W-1:0]       c1;
      logic [HUE_W-1:0]         hue;
   } stage1_type;

   typedef struct packed {
      logic [PIXEL_INDEX_W-1:0]              idx;
      logic                                  last;
      effect_type                            effect;
      span_type                              span;
      logic [CHANNELS-1:0][CHANNEL_W-1:0]    a;
      logic [CHANNELS-1:0]                   neg;
      logic [CHANNELS-1:0][PROD_W-1:0]       n;
      logic [H_W-1:0]                        h;
   } stage2_type;

   typedef struct packed {
      logic [PIXEL_INDEX_W-1:0]              idx;
      logic                                  last;
      effect_type                            effect;
      logic                                  fix;
      logic [CHANNELS-1:0][CHANNEL_W-1:0]    a;
      logic [CHANNELS-1:0]                   neg;
      logic [CHANNELS-1:0][PROD_W-1:0]       n;
      logic [CHANNELS-1:0][CHANNEL_W-1:0]    q;
      logic [COLOR_W-1:0]                    hue_rgb;
   } stage3_type;

   typedef struct packed {
      logic [PIXEL_INDEX_W-1:0]              idx;
      logic                                  last;
      logic [CHANNELS-1:0][CHANNEL_W-1:0]    rgb;
   } out_type;

   // frame iterator
   logic                     busy_ff, busy_in;
   logic [PIXEL_INDEX_W-1:0] pixel_ff, pixel_in;
   logic [PHASE_W-1:0]       offs_ff, offs_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [REM_W-1:0]         rem_sum;
   frame_type                frame_ff, frame_in;
   logic                     en;
   logic                     issue;

   // pipeline
   logic       s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   stage1_type s1_ff, s1_in;
   stage2_type s2_ff, s2_in;
   stage3_type s3_ff, s3_in;
   out_type    out_ff, out_in;

   logic [PHASE_W-1:0] p7;
   logic [PHASE_W-1:0] ph;

   function automatic logic [HUE_W-1:0] hue_of(input logic [PHASE_W-1:0] src);
      logic [22:0] w;
      w = {src, 16'b0} - {16'b0, src};
      return w[22:7];
   endfunction

   function automatic logic [COLOR_W-1:0] hue_wheel(input logic [H_W-1:0] h);
      logic [H_W-1:0] r, g, b;
      r = '0;
      g = '0;
      b = '0;
      if (h < 11'd510) begin
         if (h < 11'd255) begin
            r = 11'd255;
            g = h;
         end else begin
            r = 11'd510 - h;
            g = 11'd255;
         end
      end else if (h < 11'd1020) begin
         if (h < 11'd765) begin
            g = 11'd255;
            b = h - 11'd510;
         end else begin
            g = 11'd1020 - h;
            b = 11'd255;
         end
      end else if (h < 11'd1530) begin
         if (h < 11'd1275) begin
            r = h - 11'd1020;
            b = 11'd255;
         end else begin
            r = 11'd255;
            b = 11'd1530 - h;
         end
      end else begin
         r = 11'd255;
      end
      return {r[7:0], g[7:0], b[7:0]};
   endfunction

   // whole pipeline moves when the response register is free or being taken
   assign en    = !out_valid_ff || rsp_ch.ready;
   assign pop   = !busy_ff && !q_status.empty;
   assign issue = busy_ff && en;

   // pixel counter and running offset i*128/PIXELS (quotient plus remainder)
   assign rem_sum = rem_ff + REM_W'(REM_STEP);

   always_comb begin
      busy_in  = busy_ff;
      pixel_in = pixel_ff;
      offs_in  = offs_ff;
      rem_in   = rem_ff;
      frame_in = frame_ff;
      if (pop) begin
         busy_in  = 1'b1;
         pixel_in = '0;
         offs_in  = '0;
         rem_in   = '0;
         frame_in = q_frame;
      end else if (issue) begin
         pixel_in = pixel_ff + 1'b1;
         if (rem_sum >= REM_W'(PIXELS)) begin
            rem_in  = rem_sum - REM_W'(PIXELS);
            offs_in = offs_ff + PHASE_W'(OFFS_STEP) + 1'b1;
         end else begin
            rem_in  = rem_sum;
            offs_in = offs_ff + PHASE_W'(OFFS_STEP);
         end
         if (pixel_ff == LAST_IDX) begin
            busy_in = 1'b0;
         end
      end
   end

   // stage 1: blend position, span and end colors, or hue
   assign ph = frame_ff.phase;
   assign p7 = offs_ff + ph;

   always_comb begin
      s1_in        = '0;
      s1_in.idx    = pixel_ff;
      s1_in.last   = (pixel_ff == LAST_IDX);
      s1_in.effect = frame_ff.effect;
      s1_in.span   = SPAN_64;
      s1_in.c0     = palette.first_color;
      s1_in.c1     = palette.second_color;
      unique case (frame_ff.effect)
         EFFECT_CHASE: begin
            s1_in.span = SPAN_BASE;
            s1_in.x    = (p7 > BASE_X) ? BASE_X : p7;
         end
         EFFECT_DOUBLE_CHASE: begin
            s1_in.span = SPAN_BASE;
            s1_in.x    = ({1'b0, p7[5:0]} > BASE_X) ? BASE_X : {1'b0, p7[5:0]};
         end
         EFFECT_PULSE: begin
            s1_in.x = (ph >= HALF) ? ph - HALF : HALF - ph;
         end
         EFFECT_BLINK: begin
            s1_in.span = SPAN_32;
            s1_in.c1   = '0;
            if (ph < HALF) begin
               s1_in.x = (ph >= QUARTER) ? ph - QUARTER : QUARTER - ph;
            end else begin
               s1_in.c0 = palette.second_color;
               s1_in.x  = (ph >= THREE_Q) ? ph - THREE_Q : THREE_Q - ph;
            end
         end
         EFFECT_THEATRE: s1_in.hue = hue_of(p7);
         EFFECT_RAINBOW: s1_in.hue = hue_of(ph);
         default: ;
      endcase
   end

   // stage 2: per-channel difference times position; hue scaled onto 0..1518
   always_comb begin
      logic [CHANNEL_W-1:0] a_v, b_v, m_v;
      logic [WIDE_W-1:0]    hm;
      s2_in        = '0;
      s2_in.idx    = s1_ff.idx;
      s2_in.last   = s1_ff.last;
      s2_in.effect = s1_ff.effect;
      s2_in.span   = s1_ff.span;
      for (int c = 0; c < CHANNELS; c++) begin
         a_v = s1_ff.c0[(CHANNELS-1-c)*CHANNEL_W +: CHANNEL_W];
         b_v = s1_ff.c1[(CHANNELS-1-c)*CHANNEL_W +: CHANNEL_W];
         m_v = (b_v < a_v) ? a_v - b_v : b_v - a_v;
         s2_in.a[c]   = a_v;
         s2_in.neg[c] = (b_v < a_v);
         s2_in.n[c]   = PROD_W'(s1_ff.x) * PROD_W'(m_v);
      end
      hm       = WIDE_W'(s1_ff.hue) * WIDE_W'(HUE_SCALE) + WIDE_W'(HUE_ROUND);
      s2_in.h  = hm[RECIP_SHIFT +: H_W];
   end

   // stage 3: quotient (reciprocal estimate for the chase span); hue wheel
   always_comb begin
      logic [WIDE_W-1:0] prod_v;
      s3_in         = '0;
      s3_in.idx     = s2_ff.idx;
      s3_in.last    = s2_ff.last;
      s3_in.effect  = s2_ff.effect;
      s3_in.a       = s2_ff.a;
      s3_in.neg     = s2_ff.neg;
      s3_in.n       = s2_ff.n;
      s3_in.fix     = (s2_ff.span == SPAN_BASE);
      s3_in.hue_rgb = hue_wheel(s2_ff.h);
      for (int c = 0; c < CHANNELS; c++) begin
         prod_v = WIDE_W'(s2_ff.n[c]) * WIDE_W'(RECIP);
         unique case (s2_ff.span)
            SPAN_BASE: s3_in.q[c] = prod_v[RECIP_SHIFT +: CHANNEL_W];
            SPAN_64:   s3_in.q[c] = s2_ff.n[c][6 +: CHANNEL_W];
            SPAN_32:   s3_in.q[c] = s2_ff.n[c][5 +: CHANNEL_W];
            default:   s3_in.q[c] = '0;
         endcase
      end
   end

   // stage 4: quotient correction, signed blend, effect select
   always_comb begin
      logic [PROD_W-1:0]    corr;
      logic [CHANNEL_W-1:0] q_v;
      out_in      = '0;
      out_in.idx  = s3_ff.idx;
      out_in.last = s3_ff.last;
      for (int c = 0; c < CHANNELS; c++) begin
         corr = s3_ff.n[c] - PROD_W'(s3_ff.q[c]) * PROD_W'(BASE);
         q_v  = s3_ff.q[c] + CHANNEL_W'(s3_ff.fix && (corr >= PROD_W'(BASE)));
         unique case (s3_ff.effect)
            EFFECT_THEATRE, EFFECT_RAINBOW:
               out_in.rgb[c] = s3_ff.hue_rgb[(CHANNELS-1-c)*CHANNEL_W +: CHANNEL_W];
            EFFECT_BLACK:
               out_in.rgb[c] = '0;
            default:
               out_in.rgb[c] = s3_ff.neg[c] ? s3_ff.a[c] - q_v : s3_ff.a[c] + q_v;
         endcase
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.pixel_index = out_ff.idx;
   assign rsp_ch.red         = out_ff.rgb[0];
   assign rsp_ch.green       = out_ff.rgb[1];
   assign rsp_ch.blue        = out_ff.rgb[2];
   assign rsp_ch.last_pixel  = out_ff.last;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (en) begin
            s1_valid_ff  <= issue;
            s2_valid_ff  <= s1_valid_ff;
            s3_valid_ff  <= s2_valid_ff;
            out_valid_ff <= s3_valid_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
      offs_ff  <= offs_in;
      rem_ff   <= rem_in;
      frame_ff <= frame_in;
      if (en) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         out_ff <= out_in;
      end
   end

endmodule
